/* rtl/core/rrsp_pkg.sv */
// Shared types and codes for the role record stream parser.
// No dependencies; every other file of the block except rrsp_ifs imports this package.
package rrsp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_META   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Final status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_TRAILING  = 2'd2;

   // One queue entry: everything one input byte causes, at most a record or
   // metadata result followed by a final status.
   typedef struct packed {
      logic        rec_valid;
      logic        rec_is_meta;
      logic [31:0] record_index;
      logic [31:0] record_tag;
      logic [31:0] meta_length;
      logic [7:0]  meta_byte;
      logic        stat_valid;
      logic [1:0]  status;
      logic [31:0] total_records;
      logic [31:0] tag_limit;
   } rrsp_entry_type;

   // One result item as it leaves the block.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] record_index;
      logic [31:0] record_tag;
      logic [31:0] meta_length;
      logic [7:0]  meta_byte;
      logic [1:0]  status;
      logic [31:0] total_records;
      logic [31:0] tag_limit;
      logic        last_result;
   } rrsp_result_type;

endpackage

/* rtl/core/rrsp_ifs.sv */
// Valid/ready channel interfaces for the request and result streams.
// No dependencies.
interface rrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_buffer;

   modport source (output valid, output in_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface rrsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] record_index;
   logic [31:0] record_tag;
   logic [31:0] meta_length;
   logic [7:0]  meta_byte;
   logic [1:0]  status;
   logic [31:0] total_records;
   logic [31:0] tag_limit;
   logic        last_result;

   modport source (output valid, output kind, output record_index, output record_tag,
                   output meta_length, output meta_byte, output status,
                   output total_records, output tag_limit, output last_result,
                   input ready);
   modport sink   (input valid, input kind, input record_index, input record_tag,
                   input meta_length, input meta_byte, input status,
                   input total_records, input tag_limit, input last_result,
                   output ready);
endinterface

/* rtl/core/role_record_stream_parser_core.sv */
// Top level of the role record stream parser: front end, entry queue and result stage.
// Depends on rrsp_pkg, rrsp_ifs, rrsp_front, rrsp_queue and rrsp_back.
//
//   Channel   Direction  Handshake      Carries
//   req_bus   in         valid/ready    in_byte, end_of_buffer (one buffer byte per request)
//   rsp_bus   out        valid/ready    kind, record header fields, meta_byte, status,
//                                       total_records, tag_limit, last_result
//
// Flow: one request byte is taken every clock while the entry queue has room. A byte
// produces at most one queue entry; the result stage sends one result per clock while
// rsp_bus.ready allows, so an end-of-buffer byte that also closes a record or carries
// metadata yields two results, the record or metadata result first and the status after
// it. A result passes through the entry queue and then the output register to rsp_bus.
// Reset: synchronous and active high; it returns the parser to the start of a buffer and
// empties the queue and the output register.
// Stalls: req_bus.ready drops only while the entry queue is full, which happens when the
// result side falls behind, as under rsp_bus.ready; the sides stall independently otherwise.
//
// The front end keeps the whole parse state (phase, byte position within the current
// field, the little-endian assembly word, header count and tag limit, records and
// metadata bytes still expected, and the sticky error code). It decides per byte what
// the byte causes and pushes a single entry describing a record or metadata result
// and/or a final status. Bytes that cause nothing, such as header bytes or bytes
// dropped after an error, leave no entry. After an end-of-buffer byte the state is
// cleared so the following byte begins a new buffer.
module role_record_stream_parser_core #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   rrsp_req_if.sink   req_bus,
   rrsp_rsp_if.source rsp_bus
);
   import rrsp_pkg::*;

   logic           push_valid;
   rrsp_entry_type push_entry;
   logic           q_full;
   logic           head_valid;
   rrsp_entry_type head_entry;
   logic           pop;

   rrsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   rrsp_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   rrsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* rtl/core/rrsp_front.sv */
// Front end: accepts request bytes, runs the parse state and builds at most one queue entry per byte.
// Depends on rrsp_pkg and rrsp_req_if.
module rrsp_front (
   input  logic                    clock,
   input  logic                    reset,
   rrsp_req_if.sink                req_bus,
   input  logic                    q_full,
   output logic                    push_valid,
   output rrsp_pkg::rrsp_entry_type push_entry
);
   import rrsp_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_RECORD = 3'd1;
   localparam logic [2:0] PH_META   = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_ERROR  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bif_ff, bif_in;
   logic [31:0] asm_ff, asm_in, asm_next;
   logic [31:0] hdr_count_ff, hdr_count_in;
   logic [31:0] hdr_limit_ff, hdr_limit_in;
   logic [31:0] rec_left_ff, rec_left_in, rec_left_dec;
   logic [31:0] cur_index_ff, cur_index_in;
   logic [31:0] cur_tag_ff, cur_tag_in;
   logic [31:0] meta_left_ff, meta_left_in, meta_left_dec;
   logic [1:0]  err_ff, err_in;
   logic        accept;
   rrsp_entry_type entry;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Little-endian byte lane insert into the assembly word.
   always_comb begin
      case (bif_ff[1:0])
         2'd0:    asm_next = {asm_ff[31:8], req_bus.in_byte};
         2'd1:    asm_next = {asm_ff[31:16], req_bus.in_byte, asm_ff[7:0]};
         2'd2:    asm_next = {asm_ff[31:24], req_bus.in_byte, asm_ff[15:0]};
         default: asm_next = {req_bus.in_byte, asm_ff[23:0]};
      endcase
   end

   assign rec_left_dec  = rec_left_ff - 32'd1;
   assign meta_left_dec = meta_left_ff - 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      bif_in       = bif_ff;
      asm_in       = asm_ff;
      hdr_count_in = hdr_count_ff;
      hdr_limit_in = hdr_limit_ff;
      rec_left_in  = rec_left_ff;
      cur_index_in = cur_index_ff;
      cur_tag_in   = cur_tag_ff;
      meta_left_in = meta_left_ff;
      err_in       = err_ff;
      entry        = '0;

      case (phase_ff)
         PH_HEADER: begin
            asm_in = asm_next;
            if (bif_ff == 4'd3) begin
               hdr_count_in = asm_next;
            end else if (bif_ff == 4'd7) begin
               hdr_limit_in = asm_next;
               rec_left_in  = hdr_count_ff;
               phase_in     = (hdr_count_ff != 32'd0) ? PH_RECORD : PH_DONE;
            end
            bif_in = {1'b0, bif_ff[2:0] + 3'd1};
         end
         PH_RECORD: begin
            asm_in = asm_next;
            if (bif_ff == 4'd3) begin
               cur_index_in = asm_next;
            end else if (bif_ff == 4'd7) begin
               cur_tag_in = asm_next;
            end else if (bif_ff inside {[4'd11:4'd15]}) begin
               meta_left_in       = asm_next;
               rec_left_in        = rec_left_dec;
               entry.rec_valid    = 1'b1;
               entry.record_index = cur_index_ff;
               entry.record_tag   = cur_tag_ff;
               entry.meta_length  = asm_next;
               if (asm_next != 32'd0) begin
                  phase_in = PH_META;
               end else begin
                  phase_in = (rec_left_dec != 32'd0) ? PH_RECORD : PH_DONE;
               end
            end
            bif_in = (bif_ff inside {[4'd11:4'd15]}) ? 4'd0 : bif_ff + 4'd1;
         end
         PH_META: begin
            entry.rec_valid   = 1'b1;
            entry.rec_is_meta = 1'b1;
            entry.meta_byte   = req_bus.in_byte;
            meta_left_in      = meta_left_dec;
            if (meta_left_dec == 32'd0) begin
               phase_in = (rec_left_ff != 32'd0) ? PH_RECORD : PH_DONE;
            end
         end
         PH_DONE: begin
            err_in   = STATUS_TRAILING;
            phase_in = PH_ERROR;
         end
         default: begin
            // Error phase: bytes are dropped until the end of the buffer.
         end
      endcase

      if (req_bus.end_of_buffer) begin
         entry.stat_valid    = 1'b1;
         entry.total_records = hdr_count_in;
         entry.tag_limit     = hdr_limit_in;
         if (err_in != STATUS_OK) begin
            entry.status = err_in;
         end else if (phase_in == PH_DONE) begin
            entry.status = STATUS_OK;
         end else begin
            entry.status = STATUS_TRUNCATED;
         end
         // The next byte starts a fresh buffer.
         phase_in     = PH_HEADER;
         bif_in       = '0;
         asm_in       = '0;
         hdr_count_in = '0;
         hdr_limit_in = '0;
         rec_left_in  = '0;
         cur_index_in = '0;
         cur_tag_in   = '0;
         meta_left_in = '0;
         err_in       = STATUS_OK;
      end
   end

   assign push_valid = accept && (entry.rec_valid || entry.stat_valid);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         bif_ff       <= '0;
         asm_ff       <= '0;
         hdr_count_ff <= '0;
         hdr_limit_ff <= '0;
         rec_left_ff  <= '0;
         cur_index_ff <= '0;
         cur_tag_ff   <= '0;
         meta_left_ff <= '0;
         err_ff       <= STATUS_OK;
      end else if (accept) begin
         phase_ff     <= phase_in;
         bif_ff       <= bif_in;
         asm_ff       <= asm_in;
         hdr_count_ff <= hdr_count_in;
         hdr_limit_ff <= hdr_limit_in;
         rec_left_ff  <= rec_left_in;
         cur_index_ff <= cur_index_in;
         cur_tag_ff   <= cur_tag_in;
         meta_left_ff <= meta_left_in;
         err_ff       <= err_in;
      end
   end

endmodule

/* rtl/core/rrsp_queue.sv */
// Small FIFO of parse entries between the front end and the result stage.
// Depends on rrsp_pkg.
module rrsp_queue #(
   parameter int QueueDepth = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  rrsp_pkg::rrsp_entry_type push_entry,
   output logic                     q_full,
   output logic                     head_valid,
   output rrsp_pkg::rrsp_entry_type head_entry,
   input  logic                     pop
);
   import rrsp_pkg::*;

   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(QueueDepth);

   rrsp_entry_type          mem_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign q_full     = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The front end holds off whenever the queue is full.
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_full))
      else $error("queue written while full");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count out of step with pushes");

endmodule

/* rtl/core/rrsp_back.sv */
// Result stage: expands queue entries into one or two results behind an output register.
// Depends on rrsp_pkg and rrsp_rsp_if.
module rrsp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  rrsp_pkg::rrsp_entry_type head_entry,
   output logic                     pop,
   rrsp_rsp_if.source               rsp_bus
);
   import rrsp_pkg::*;

   logic            rsp_valid_ff;
   rrsp_result_type rsp_data_ff, rsp_data_in;
   logic            part_ff, part_in;
   logic            out_free;
   logic            load;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign load     = out_free && head_valid;

   // part_ff set means the record half of the head entry is already out.
   always_comb begin
      rsp_data_in = '0;
      part_in     = part_ff;
      pop         = 1'b0;
      if (head_entry.rec_valid && !part_ff) begin
         if (head_entry.rec_is_meta) begin
            rsp_data_in.kind      = KIND_META;
            rsp_data_in.meta_byte = head_entry.meta_byte;
         end else begin
            rsp_data_in.kind         = KIND_RECORD;
            rsp_data_in.record_index = head_entry.record_index;
            rsp_data_in.record_tag   = head_entry.record_tag;
            rsp_data_in.meta_length  = head_entry.meta_length;
         end
         rsp_data_in.last_result = !head_entry.stat_valid;
         if (load) begin
            pop     = !head_entry.stat_valid;
            part_in = head_entry.stat_valid;
         end
      end else begin
         rsp_data_in.kind          = KIND_STATUS;
         rsp_data_in.status        = head_entry.status;
         rsp_data_in.total_records = head_entry.total_records;
         rsp_data_in.tag_limit     = head_entry.tag_limit;
         rsp_data_in.last_result   = 1'b1;
         if (load) begin
            pop     = 1'b1;
            part_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         part_ff      <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= head_valid;
         end
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_data_ff.kind;
   assign rsp_bus.record_index  = rsp_data_ff.record_index;
   assign rsp_bus.record_tag    = rsp_data_ff.record_tag;
   assign rsp_bus.meta_length   = rsp_data_ff.meta_length;
   assign rsp_bus.meta_byte     = rsp_data_ff.meta_byte;
   assign rsp_bus.status        = rsp_data_ff.status;
   assign rsp_bus.total_records = rsp_data_ff.total_records;
   assign rsp_bus.tag_limit     = rsp_data_ff.tag_limit;
   assign rsp_bus.last_result   = rsp_data_ff.last_result;

   // Half-sent entries always carry a status still to go.
   a_part_has_status : assert property (@(posedge clock) disable iff (reset)
      part_ff |-> (head_valid && head_entry.stat_valid && head_entry.rec_valid))
      else $error("second half pending on an entry without a status");

endmodule
